// File: design/wti_pkg.sv
package wti_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int SAMPLE_WIDTH = 32;

    localparam int FIELD_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DX_W       = SAMPLE_WIDTH + 1;
    localparam int PROD_W     = 2 * DX_W;
    localparam int AREA_W     = 64;
    localparam int RANGE_W    = 40;
    localparam int CLAMP_W    = (PROD_W > AREA_W) ? PROD_W : AREA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_TRAPEZOID = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END    = CFG_IDX_W'(2);

    localparam logic signed [FIELD_W-1:0] WIN_START_RST = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic signed [FIELD_W-1:0] WIN_END_RST   = {1'b0, {(FIELD_W-1){1'b1}}};

    localparam logic signed [AREA_W-1:0] AREA_MAX     = {1'b0, {(AREA_W-1){1'b1}}};
    localparam logic signed [AREA_W-1:0] AREA_MIN     = {1'b1, {(AREA_W-1){1'b0}}};
    localparam logic signed [AREA_W-1:0] AREA_SEG_MIN = -AREA_MAX;

    localparam logic signed [RANGE_W-1:0] RANGE_MAX = {1'b0, {(RANGE_W-1){1'b1}}};
    localparam logic signed [RANGE_W-1:0] RANGE_MIN = {1'b1, {(RANGE_W-1){1'b0}}};

    localparam logic signed [CLAMP_W-1:0] SEG_MAX = CLAMP_W'(AREA_MAX);
    localparam logic signed [CLAMP_W-1:0] SEG_MIN = CLAMP_W'(AREA_SEG_MIN);

    // rounding bias so that the arithmetic shift truncates toward zero
    localparam logic signed [PROD_W-1:0] BIAS_RECT =
        (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] BIAS_TRAP =
        (PROD_W'(1) << (FRAC_BITS + 1)) - PROD_W'(1);

    typedef struct packed {
        logic signed [AREA_W-1:0] seg;
        logic signed [DX_W-1:0]   dx;
        logic                     last;
    } seg_item_t;

endpackage

// File: design/wti_accum.sv
module wti_accum (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  wti_pkg::seg_item_t                item,
    output logic                              item_take,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [wti_pkg::AREA_W-1:0] area_sum,
    output logic signed [wti_pkg::RANGE_W-1:0] covered_range
);
    import wti_pkg::*;

    logic signed [AREA_W-1:0]  area_acc_reg;
    logic signed [AREA_W-1:0]  area_acc_next;
    logic signed [RANGE_W-1:0] range_acc_reg;
    logic signed [RANGE_W-1:0] range_acc_next;
    logic signed [AREA_W:0]    area_wide;
    logic signed [RANGE_W:0]   range_wide;
    logic                      result_valid_reg;
    logic signed [AREA_W-1:0]  area_sum_reg;
    logic signed [RANGE_W-1:0] covered_range_reg;

    assign item_take = item_valid && (!item.last || !result_valid_reg || result_ready);

    assign area_wide  = (AREA_W+1)'(area_acc_reg) + (AREA_W+1)'(item.seg);
    assign range_wide = (RANGE_W+1)'(range_acc_reg) + (RANGE_W+1)'(item.dx);

    always_comb
    begin
        if (area_wide[AREA_W] != area_wide[AREA_W-1])
        begin
            area_acc_next = area_wide[AREA_W] ? AREA_MIN : AREA_MAX;
        end
        else
        begin
            area_acc_next = area_wide[AREA_W-1:0];
        end
        if (range_wide[RANGE_W] != range_wide[RANGE_W-1])
        begin
            range_acc_next = range_wide[RANGE_W] ? RANGE_MIN : RANGE_MAX;
        end
        else
        begin
            range_acc_next = range_wide[RANGE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_acc_reg     <= '0;
            range_acc_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                if (item.last)
                begin
                    area_acc_reg  <= '0;
                    range_acc_reg <= '0;
                end
                else
                begin
                    area_acc_reg  <= area_acc_next;
                    range_acc_reg <= range_acc_next;
                end
            end
            if (item_take && item.last)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && item.last)
        begin
            area_sum_reg      <= area_acc_next;
            covered_range_reg <= range_acc_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign area_sum      = area_sum_reg;
    assign covered_range = covered_range_reg;

endmodule

// File: design/windowed_trapezoid_integrator.sv
// Throughput: one sample per cycle through a four-stage pipeline
// (difference, multiply, scale, accumulate); sample_ready drops only while a
// result is held and a further last item is waiting behind it.
// Reset (asynchronous, active low) restores register defaults and clears
// curve state, accumulators and pipeline valids.
module windowed_trapezoid_integrator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [wti_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wti_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [wti_pkg::FIELD_W-1:0]    x_sample,
    input  logic signed [wti_pkg::FIELD_W-1:0]    y_sample,
    input  logic                                  is_last,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [wti_pkg::AREA_W-1:0]     area_sum,
    output logic signed [wti_pkg::RANGE_W-1:0]    covered_range
);
    import wti_pkg::*;

    logic                      use_trapezoid_reg;
    logic signed [FIELD_W-1:0] window_start_reg;
    logic signed [FIELD_W-1:0] window_end_reg;

    logic signed [SAMPLE_WIDTH-1:0] prev_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_y_reg;
    logic                           have_prev_reg;

    logic signed [SAMPLE_WIDTH-1:0] x_trim;
    logic signed [SAMPLE_WIDTH-1:0] y_trim;
    logic                           counted;
    logic signed [DX_W-1:0]         dx_next;
    logic signed [DX_W-1:0]         a_next;
    logic                           accept;

    logic                   d_valid_reg;
    logic signed [DX_W-1:0] d_dx_reg;
    logic signed [DX_W-1:0] d_a_reg;
    logic                   d_trap_reg;
    logic                   d_last_reg;

    logic                     p_valid_reg;
    logic signed [PROD_W-1:0] p_prod_reg;
    logic signed [DX_W-1:0]   p_dx_reg;
    logic                     p_trap_reg;
    logic                     p_last_reg;

    logic signed [PROD_W-1:0]  biased;
    logic signed [PROD_W-1:0]  scaled;
    logic signed [CLAMP_W-1:0] scaled_w;
    logic signed [AREA_W-1:0]  seg_next;

    logic      s_valid_reg;
    seg_item_t s_item_reg;
    logic      acc_take;

    logic load_s;
    logic load_p;
    logic load_d;

    assign load_s       = !s_valid_reg || acc_take;
    assign load_p       = !p_valid_reg || load_s;
    assign load_d       = !d_valid_reg || load_p;
    assign sample_ready = load_d;
    assign accept       = sample_valid && sample_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_trapezoid_reg <= 1'b1;
            window_start_reg  <= WIN_START_RST;
            window_end_reg    <= WIN_END_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_USE_TRAPEZOID: use_trapezoid_reg <= cfg_data[0];
                CFG_WINDOW_START:  window_start_reg  <= cfg_data;
                CFG_WINDOW_END:    window_end_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // stage 1: segment difference and multiplicand
    assign x_trim  = x_sample[SAMPLE_WIDTH-1:0];
    assign y_trim  = y_sample[SAMPLE_WIDTH-1:0];
    assign counted = have_prev_reg && (prev_x_reg >= window_start_reg)
                     && (prev_x_reg <= window_end_reg);

    always_comb
    begin
        dx_next = '0;
        a_next  = '0;
        if (counted)
        begin
            dx_next = DX_W'(x_trim) - DX_W'(prev_x_reg);
            a_next  = use_trapezoid_reg ? (DX_W'(prev_y_reg) + DX_W'(y_trim))
                                        : DX_W'(prev_y_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            d_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                have_prev_reg <= !is_last;
                prev_x_reg    <= is_last ? '0 : x_trim;
                prev_y_reg    <= is_last ? '0 : y_trim;
            end
            if (load_d)
            begin
                d_valid_reg <= accept;
            end
            if (load_p)
            begin
                p_valid_reg <= d_valid_reg;
            end
            if (load_s)
            begin
                s_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_dx_reg   <= dx_next;
            d_a_reg    <= a_next;
            d_trap_reg <= use_trapezoid_reg;
            d_last_reg <= is_last;
        end
        if (load_p && d_valid_reg)
        begin
            p_prod_reg <= PROD_W'(d_a_reg) * PROD_W'(d_dx_reg);
            p_dx_reg   <= d_dx_reg;
            p_trap_reg <= d_trap_reg;
            p_last_reg <= d_last_reg;
        end
        if (load_s && p_valid_reg)
        begin
            s_item_reg.seg  <= seg_next;
            s_item_reg.dx   <= p_dx_reg;
            s_item_reg.last <= p_last_reg;
        end
    end

    // stage 3: scale with truncation toward zero, clamp magnitude
    always_comb
    begin
        biased = p_prod_reg;
        if (p_prod_reg[PROD_W-1])
        begin
            biased = p_prod_reg + (p_trap_reg ? BIAS_TRAP : BIAS_RECT);
        end
        scaled   = p_trap_reg ? (biased >>> (FRAC_BITS + 1)) : (biased >>> FRAC_BITS);
        scaled_w = CLAMP_W'(scaled);
        if (scaled_w > SEG_MAX)
        begin
            seg_next = AREA_MAX;
        end
        else if (scaled_w < SEG_MIN)
        begin
            seg_next = AREA_SEG_MIN;
        end
        else
        begin
            seg_next = scaled_w[AREA_W-1:0];
        end
    end

    wti_accum u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (s_valid_reg),
        .item          (s_item_reg),
        .item_take     (acc_take),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .area_sum      (area_sum),
        .covered_range (covered_range)
    );

endmodule

// File: design/wti_checker.sv
module wti_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               sample_valid,
    input logic                               sample_ready,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic signed [wti_pkg::AREA_W-1:0]  area_sum,
    input logic signed [wti_pkg::RANGE_W-1:0] covered_range
);

    // a held result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(area_sum) && $stable(covered_range))
        else $error("result changed while stalled");

    // input back-pressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid && !result_ready)
        else $error("sample_ready low without blocked result");

    // reset empties the pipeline
    a_reset_state: assert property (@(posedge clk)
        !rst_n |-> !result_valid && sample_ready)
        else $error("pipeline not empty in reset");

    // a presented result carries known data
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !$isunknown({area_sum, covered_range}))
        else $error("result payload unknown");

endmodule

bind windowed_trapezoid_integrator wti_checker u_checker (.*);

// File: verif/windowed_trapezoid_integrator_tb.sv
`timescale 1ns / 1ps

module windowed_trapezoid_integrator_tb;

    import wti_pkg::*;

    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic signed [AREA_W-1:0]  area;
        logic signed [RANGE_W-1:0] span;
    } area_result_t;

    typedef enum logic [2:0] {
        ROW_ITEM,
        ROW_SET_TRAP,
        ROW_SET_START,
        ROW_SET_END,
        ROW_SET_UNUSED
    } row_kind_t;

    // x carries the write data on register rows
    typedef struct packed {
        row_kind_t                 kind;
        logic signed [31:0]        x;
        logic signed [31:0]        y;
        logic                      last;
        logic                      typed;
        logic signed [AREA_W-1:0]  area;
        logic signed [RANGE_W-1:0] span;
    } row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      sample_valid;
    logic                      sample_ready;
    logic signed [FIELD_W-1:0] x_sample;
    logic signed [FIELD_W-1:0] y_sample;
    logic                      is_last;
    logic                      result_valid;
    logic                      result_ready;
    logic signed [AREA_W-1:0]  area_sum;
    logic signed [RANGE_W-1:0] covered_range;

    windowed_trapezoid_integrator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .x_sample      (x_sample),
        .y_sample      (y_sample),
        .is_last       (is_last),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .area_sum      (area_sum),
        .covered_range (covered_range)
    );

    // predictor state and register copy
    logic                      trap_mode   = 1'b1;
    logic signed [31:0]        win_lo      = S_MIN;
    logic signed [31:0]        win_hi      = S_MAX;
    logic signed [31:0]        cur_x       = '0;
    logic signed [31:0]        cur_y       = '0;
    logic                      seen_prev   = 1'b0;
    logic signed [AREA_W-1:0]  area_total  = '0;
    logic signed [RANGE_W-1:0] range_total = '0;

    area_result_t pending_totals [$];
    int           mismatches    = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    logic         hold_req      = 1'b0;
    int           hold_left     = 0;
    int           cycle_count   = 0;

    row_t directed_rows [30] = '{
        '{ROW_ITEM, 327680, 65536, 1'b1, 1'b1, 64'sd0, 40'sd0},
        '{ROW_ITEM, 0, 0, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 65536, 131072, 1'b1, 1'b1, 64'sd65536, 40'sd65536},
        '{ROW_ITEM, S_MIN, S_MIN, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, S_MAX, S_MAX, 1'b1, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, S_MAX, S_MAX, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, S_MIN, S_MIN, 1'b1, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 0, -32'sd65537, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 1, -32'sd65536, 1'b1, 1'b0, 64'sd0, 40'sd0},
        '{ROW_SET_TRAP, 32'shFFFF_FFFE, 0, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_SET_START, 0, 0, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_SET_END, 262144, 0, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, -32'sd65536, 7, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 0, 196608, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 131072, 327680, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 262144, 65536, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 589824, 65536, 1'b1, 1'b0, 64'sd0, 40'sd0},
        '{ROW_SET_UNUSED, 0, 0, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_SET_START, S_MAX, 0, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_SET_END, S_MIN, 0, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_SET_TRAP, 1, 0, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 0, 65536, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 6553600, 65536, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 3, 3, 1'b1, 1'b1, 64'sd0, 40'sd0},
        '{ROW_SET_START, 131072, 0, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_SET_END, 131072, 0, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 65536, 65536, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 131072, -32'sd131072, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, 196608, S_MAX, 1'b0, 1'b0, 64'sd0, 40'sd0},
        '{ROW_ITEM, -32'sd5, S_MIN, 1'b1, 1'b0, 64'sd0, 40'sd0}
    };

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAIL windowed_trapezoid_integrator");
                $finish;
            end
        end
    end

    // truncates the product magnitude toward zero
    function automatic logic signed [63:0] scaled_product(input logic signed [33:0] a,
                                                          input logic signed [33:0] b,
                                                          input int sh);
        logic signed [67:0] prod;
        logic [67:0]        mag;
        prod = a * b;
        mag = (prod < 0) ? -prod : prod;
        mag = mag >> sh;
        if (mag > 68'h7FFF_FFFF_FFFF_FFFF)
            mag = 68'h7FFF_FFFF_FFFF_FFFF;
        return (prod < 0) ? -$signed(mag[63:0]) : $signed(mag[63:0]);
    endfunction

    task automatic integrate_sample(input logic signed [31:0] x, input logic signed [31:0] y,
                                    input logic last, output logic emit,
                                    output area_result_t totals);
        logic signed [32:0]        dx;
        logic signed [32:0]        ysum;
        logic signed [AREA_W-1:0]  seg;
        logic signed [AREA_W:0]    asum;
        logic signed [RANGE_W:0]   rsum;
        if (seen_prev && cur_x >= win_lo && cur_x <= win_hi)
        begin
            dx = $signed({x[31], x}) - $signed({cur_x[31], cur_x});
            ysum = $signed({cur_y[31], cur_y}) + $signed({y[31], y});
            if (trap_mode)
                seg = scaled_product(ysum, dx, FRAC_BITS + 1);
            else
                seg = scaled_product(cur_y, dx, FRAC_BITS);
            asum = area_total + seg;
            if (asum > AREA_MAX)
                area_total = AREA_MAX;
            else if (asum < AREA_MIN)
                area_total = AREA_MIN;
            else
                area_total = asum[AREA_W-1:0];
            rsum = range_total + dx;
            if (rsum > RANGE_MAX)
                range_total = RANGE_MAX;
            else if (rsum < RANGE_MIN)
                range_total = RANGE_MIN;
            else
                range_total = rsum[RANGE_W-1:0];
        end
        cur_x = x;
        cur_y = y;
        seen_prev = 1'b1;
        emit = last;
        totals.area = area_total;
        totals.span = range_total;
        if (last)
        begin
            cur_x = '0;
            cur_y = '0;
            seen_prev = 1'b0;
            area_total = '0;
            range_total = '0;
        end
    endtask

    task automatic send_sample(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic last, input logic typed,
                               input area_result_t fixed);
        area_result_t predicted;
        logic         emit;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        x_sample <= x;
        y_sample <= y;
        is_last <= last;
        do
            @(posedge clk);
        while (!sample_ready);
        integrate_sample(x, y, last, emit, predicted);
        if (emit)
            pending_totals.push_back(typed ? fixed : predicted);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_USE_TRAPEZOID: trap_mode = data[0];
            CFG_WINDOW_START:  win_lo = data;
            CFG_WINDOW_END:    win_hi = data;
            default: ;
        endcase
    endtask

    // block must be idle before any register write
    task automatic drain();
        sample_valid <= 1'b0;
        cfg_we <= 1'b0;
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] trap, input logic signed [31:0] lo,
                                  input logic signed [31:0] hi);
        drain();
        write_reg(CFG_USE_TRAPEZOID, trap);
        write_reg(CFG_WINDOW_START, lo);
        write_reg(CFG_WINDOW_END, hi);
        cfg_we <= 1'b0;
    endtask

    task automatic random_settings();
        logic signed [31:0] a;
        logic signed [31:0] b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(4))
            0:
            begin
                a = S_MIN;
                b = S_MAX;
            end
            1:
            begin
                if (a < b)
                    {a, b} = {b, a};
                if (a == b)
                begin
                    a = S_MAX;
                    b = S_MIN;
                end
            end
            2:
            begin
                if (a > b)
                    {a, b} = {b, a};
            end
            3: b = a;
            default:
            begin
                if ($urandom_range(1))
                    a = S_MIN;
                else
                    b = S_MAX;
                if (a > b)
                    {a, b} = {b, a};
            end
        endcase
        apply_settings($urandom, a, b);
    endtask

    // mostly ordered curves near the window, some raw noise
    task automatic random_curves(input int n_items);
        int                 sent;
        int                 len;
        int                 k;
        logic               shaped;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] step;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 10);
            shaped = ($urandom_range(3) != 0);
            x = $urandom_range(1) ? $urandom : win_lo - $urandom_range(0, 1 << 22);
            for (k = 0; k < len; k++)
            begin
                if (shaped && $urandom_range(9) != 0)
                begin
                    step = $urandom_range(0, 1 << 22);
                    if ($urandom_range(4) == 0)
                        step = -step;
                    x = x + step;
                    y = $urandom;
                    y = y >>> $urandom_range(0, 20);
                end
                else
                begin
                    x = $urandom;
                    y = $urandom;
                end
                send_sample(x, y, k == len - 1, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // counts rising edges and one final falling edge, drives the range total into saturation
    task automatic sawtooth_curve();
        int i;
        apply_settings(1, S_MIN, -32'sd1);
        for (i = 0; i < 132; i++)
        begin
            send_sample(S_MIN + $urandom_range(0, 1000), $urandom, 1'b0, 1'b0, '0);
            send_sample(S_MAX - $urandom_range(0, 1000), $urandom, 1'b0, 1'b0, '0);
        end
        send_sample(-32'sd1, $urandom, 1'b0, 1'b0, '0);
        send_sample(S_MIN, $urandom, 1'b1, 1'b0, '0);
    endtask

    initial
    begin
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        area_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_totals.size() == 0)
            begin
                $error("unexpected result: area_sum %0d covered_range %0d",
                       area_sum, covered_range);
                mismatches++;
            end
            else
            begin
                want = pending_totals.pop_front();
                if (area_sum !== want.area)
                begin
                    $error("area_sum expected %0d actual %0d", want.area, area_sum);
                    mismatches++;
                end
                if (covered_range !== want.span)
                begin
                    $error("covered_range expected %0d actual %0d", want.span, covered_range);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        area_result_t fixed;
        int           i;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        sample_valid <= 1'b0;
        x_sample <= '0;
        y_sample <= '0;
        is_last <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 35;
        recv_idle_pct = 74;
        for (i = 0; i < 30; i++)
        begin
            fixed.area = directed_rows[i].area;
            fixed.span = directed_rows[i].span;
            if (directed_rows[i].kind == ROW_ITEM)
            begin
                cfg_we <= 1'b0;
                send_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                            directed_rows[i].typed, fixed);
            end
            else
            begin
                drain();
                case (directed_rows[i].kind)
                    ROW_SET_TRAP:  write_reg(CFG_USE_TRAPEZOID, directed_rows[i].x);
                    ROW_SET_START: write_reg(CFG_WINDOW_START, directed_rows[i].x);
                    ROW_SET_END:   write_reg(CFG_WINDOW_END, directed_rows[i].x);
                    default:       write_reg(CFG_UNUSED, directed_rows[i].x);
                endcase
            end
        end
        random_settings();
        random_curves(50);
        random_settings();
        random_curves(50);

        send_idle_pct = 74;
        recv_idle_pct = 35;
        random_settings();
        random_curves(40);
        // burst of short curves against a stalled receiver
        send_idle_pct = 0;
        hold_req = 1'b1;
        for (i = 0; i < 24; i++)
            send_sample($urandom, $urandom, (i == 23) || ($urandom_range(3) != 0), 1'b0, '0);
        send_idle_pct = 74;
        random_settings();
        random_curves(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        sawtooth_curve();
        random_settings();
        random_curves(60);

        sample_valid <= 1'b0;
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS windowed_trapezoid_integrator");
        else
            $display("FAIL windowed_trapezoid_integrator");
        $finish;
    end

endmodule
